>>> rtl/gst_pkg.sv
// ---------------------------------------------------------------------------
// gst_pkg: shared types and constants for the generational slot table
// Field widths, action and status codes, and the sequencer state type.
// ---------------------------------------------------------------------------
package gst_pkg;

	localparam int HASH_W = 64;
	localparam int GEN_W  = 32;
	localparam int HIDX_W = 16;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 3;
	localparam int NUM_W  = 6;
	localparam int LIVE_W = 7;

	localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

	typedef enum logic [ACT_W-1:0] {
		ACT_REGISTER   = 2'd0,
		ACT_RESOLVE    = 2'd1,
		ACT_UNREGISTER = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STS_OK    = 3'd0,
		STS_RANGE = 3'd1,
		STS_STALE = 3'd2,
		STS_FREED = 3'd3,
		STS_FULL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_POP,
		S_GEN,
		S_CHK1,
		S_CHK2,
		S_DONE
	} state_t;

endpackage

>>> rtl/gst_slot_mem.sv
// ---------------------------------------------------------------------------
// gst_slot_mem: slot hash and generation store
// One write port and one read port shared by hash and generation; read data
// is registered. Contents are undefined until written.
// ---------------------------------------------------------------------------
module gst_slot_mem
	import gst_pkg::*;
#(
	parameter int SLOTS = 64,
	parameter int IDX_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [HASH_W-1:0] wr_hash,
	input  logic [GEN_W-1:0]  wr_gen,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [HASH_W-1:0] rd_hash,
	output logic [GEN_W-1:0]  rd_gen
);

	logic [HASH_W-1:0] hash_mem [SLOTS];
	logic [GEN_W-1:0]  gen_mem  [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hash_mem[wr_addr] <= wr_hash;
			gen_mem[wr_addr]  <= wr_gen;
		end
	end

	always_ff @(posedge clk) begin
		rd_hash <= hash_mem[rd_addr];
		rd_gen  <= gen_mem[rd_addr];
	end

endmodule

>>> rtl/generational_slot_table.sv
// Register scans the allocated slots for a live entry with the same hash (dedup hit), else
// pops a freed slot and writes it back with its generation incremented, or takes a never-used slot.
// Resolve and unregister read the slot and check it; an unused action goes straight to the result.
// One transaction in flight; s_tready is high only while idle, so the next item is taken
// only after the last result is registered, later while m_tready holds a result back.
// Reset clears live bits, counters and valid flags; slot store and free stack are not.
// ---------------------------------------------------------------------------
// generational_slot_table: handle table with dedup on content hash
// Register, resolve and unregister actions on SLOTS generational slots,
// run by a small sequencer around one slot store read port.
// ---------------------------------------------------------------------------
module generational_slot_table
	import gst_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] asset_hash, [79:64] handle_index, [111:80] handle_generation
	input  logic [111:0] s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] status, [8:3] slot_number, [40:9] slot_generation,
	// [104:41] stored_hash, [105] dedup_hit, [112:106] live_slots, [119:113] zero
	output logic [119:0] m_tdata
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

	function automatic logic [NUM_W-1:0] to_num(input logic [IDX_W-1:0] idx);
		logic [IDX_W+NUM_W-1:0] w;
		w = {{NUM_W{1'b0}}, idx};
		return w[NUM_W-1:0];
	endfunction

	function automatic logic [LIVE_W-1:0] to_live(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+LIVE_W-1:0] w;
		w = {{LIVE_W{1'b0}}, cnt};
		return w[LIVE_W-1:0];
	endfunction

	state_t state_q, state_d;

	action_t             act_q;
	logic [HASH_W-1:0]   hash_q;
	logic [HIDX_W-1:0]   idx_q;
	logic [GEN_W-1:0]    gen_q;
	logic [CNT_W-1:0]    scan_cnt_q;
	logic                rd_pend_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic [IDX_W-1:0]    slot_q;
	logic [CNT_W-1:0]    alloc_q;
	logic [CNT_W-1:0]    free_top_q;
	logic [CNT_W-1:0]    live_cnt_q;
	logic [SLOTS-1:0]    live_q;
	status_t             res_status_q;
	logic [NUM_W-1:0]    res_num_q;
	logic [GEN_W-1:0]    res_gen_q;
	logic [HASH_W-1:0]   res_hash_q;
	logic                res_dedup_q;
	logic                m_tvalid_q;
	logic [119:0]        m_tdata_q;

	logic                mem_wr_en;
	logic [IDX_W-1:0]    mem_wr_addr;
	logic [HASH_W-1:0]   mem_wr_hash;
	logic [GEN_W-1:0]    mem_wr_gen;
	logic [IDX_W-1:0]    mem_rd_addr;
	logic [HASH_W-1:0]   mem_rd_hash;
	logic [GEN_W-1:0]    mem_rd_gen;

	logic [IDX_W-1:0]    fs_mem [SLOTS];
	logic                fs_wr_en;
	logic [IDX_W-1:0]    fs_rd_q;
	logic [CNT_W-1:0]    fs_top_m1;

	logic                in_acc;
	logic                out_free;
	logic                scan_issue;
	logic                scan_hit;
	logic                scan_miss;
	logic                has_room;
	logic                range_ok;
	status_t             chk_status;
	logic [GEN_W-1:0]    gen_inc;

	gst_slot_mem #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_hash (mem_wr_hash),
		.wr_gen  (mem_wr_gen),
		.rd_addr (mem_rd_addr),
		.rd_hash (mem_rd_hash),
		.rd_gen  (mem_rd_gen)
	);

	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign scan_issue = scan_cnt_q < alloc_q;
	assign scan_hit   = rd_pend_q && live_q[rd_addr_q] && (mem_rd_hash == hash_q);
	assign scan_miss  = !scan_issue && !rd_pend_q;
	assign has_room   = alloc_q < SLOTS_C;
	assign range_ok   = 32'(idx_q) < 32'(alloc_q);
	assign gen_inc    = mem_rd_gen + GEN_FIRST;
	assign fs_top_m1  = free_top_q - CNT_W'(1);

	always_comb begin
		priority if (!range_ok) begin
			chk_status = STS_RANGE;
		end else if (mem_rd_gen != gen_q) begin
			chk_status = STS_STALE;
		end else if (!live_q[idx_q[IDX_W-1:0]]) begin
			chk_status = STS_FREED;
		end else begin
			chk_status = STS_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (action_t'(s_tuser))
						ACT_REGISTER:                state_d = S_SCAN;
						ACT_RESOLVE, ACT_UNREGISTER: state_d = S_CHK1;
						ACT_NONE:                    state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_DONE;
				end else if (scan_miss) begin
					state_d = (free_top_q != '0) ? S_POP : S_DONE;
				end
			end
			S_POP:  state_d = S_GEN;
			S_GEN:  state_d = S_DONE;
			S_CHK1: state_d = S_CHK2;
			S_CHK2: state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store controls
	always_comb begin
		s_tready    = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_hash = hash_q;
		mem_wr_gen  = gen_inc;
		fs_wr_en    = 1'b0;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_SCAN: begin
				mem_rd_addr = scan_cnt_q[IDX_W-1:0];
				// take a never-used slot
				if (!scan_hit && scan_miss && free_top_q == '0 && has_room) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = alloc_q[IDX_W-1:0];
					mem_wr_gen  = GEN_FIRST;
				end
			end
			S_POP: mem_rd_addr = fs_rd_q;
			S_GEN: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_q;
			end
			S_CHK1: mem_rd_addr = idx_q[IDX_W-1:0];
			S_CHK2: begin
				if (chk_status == STS_OK && act_q == ACT_UNREGISTER) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = idx_q[IDX_W-1:0];
					mem_wr_hash = mem_rd_hash;
					fs_wr_en    = free_top_q < SLOTS_C;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// free stack: read at the top entry every cycle
	always_ff @(posedge clk) begin
		if (fs_wr_en) fs_mem[free_top_q[IDX_W-1:0]] <= idx_q[IDX_W-1:0];
		fs_rd_q <= fs_mem[fs_top_m1[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_cnt_q <= '0;
			rd_pend_q  <= 1'b0;
			alloc_q    <= '0;
			free_top_q <= '0;
			live_cnt_q <= '0;
			live_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				scan_cnt_q <= '0;
				rd_pend_q  <= 1'b0;
			end
			unique case (state_q)
				S_SCAN: begin
					rd_pend_q <= scan_issue && !scan_hit;
					if (scan_issue && !scan_hit) scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					if (!scan_hit && scan_miss) begin
						if (free_top_q != '0) begin
							free_top_q <= fs_top_m1;
						end else if (has_room) begin
							alloc_q                      <= alloc_q + CNT_W'(1);
							live_q[alloc_q[IDX_W-1:0]]   <= 1'b1;
							live_cnt_q                   <= live_cnt_q + CNT_W'(1);
						end
					end
				end
				S_GEN: begin
					live_q[slot_q] <= 1'b1;
					live_cnt_q     <= live_cnt_q + CNT_W'(1);
				end
				S_CHK2: begin
					if (chk_status == STS_OK && act_q == ACT_UNREGISTER) begin
						live_q[idx_q[IDX_W-1:0]] <= 1'b0;
						if (free_top_q < SLOTS_C) free_top_q <= free_top_q + CNT_W'(1);
						if (live_cnt_q != '0) live_cnt_q <= live_cnt_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q        <= action_t'(s_tuser);
			hash_q       <= s_tdata[63:0];
			idx_q        <= s_tdata[79:64];
			gen_q        <= s_tdata[111:80];
			res_status_q <= STS_OK;
			res_num_q    <= '0;
			res_gen_q    <= '0;
			res_hash_q   <= '0;
			res_dedup_q  <= 1'b0;
		end
		unique case (state_q)
			S_SCAN: begin
				rd_addr_q <= scan_cnt_q[IDX_W-1:0];
				if (scan_hit) begin
					res_num_q   <= to_num(rd_addr_q);
					res_gen_q   <= mem_rd_gen;
					res_dedup_q <= 1'b1;
				end else if (scan_miss && free_top_q == '0) begin
					if (has_room) begin
						res_num_q <= to_num(alloc_q[IDX_W-1:0]);
						res_gen_q <= GEN_FIRST;
					end else begin
						res_status_q <= STS_FULL;
					end
				end
			end
			S_POP: slot_q <= fs_rd_q;
			S_GEN: begin
				res_num_q <= to_num(slot_q);
				res_gen_q <= gen_inc;
			end
			S_CHK2: begin
				res_status_q <= chk_status;
				res_num_q    <= idx_q[NUM_W-1:0];
				if (chk_status == STS_OK && act_q == ACT_RESOLVE) res_hash_q <= mem_rd_hash;
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {7'd0, to_live(live_cnt_q), res_dedup_q, res_hash_q,
						res_gen_q, res_num_q, res_status_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/gst_checker.sv
// ---------------------------------------------------------------------------
// gst_checker: port-level checks for the generational slot table
// Watches the stream ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module gst_checker
	import gst_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one transaction at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	a_dedup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[105] |-> m_tdata[2:0] == STS_OK && m_tdata[40:9] != '0)
		else $error("dedup hit without a valid handle");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != STS_OK |-> m_tdata[105:9] == '0)
		else $error("error result carries payload");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[112:106]) <= SLOTS)
		else $error("live count exceeds table size");

endmodule

bind generational_slot_table gst_checker #(.SLOTS(SLOTS)) u_gst_checker (.*);
